@@ sv/stm_pkg.sv @@
// Shared widths and constants for the six thruster mixer.
`timescale 1ns / 1ps

package stm_pkg;

    // Fixed point format of the axis commands
    localparam int FRAC_BITS = 14;

    // Port field widths
    localparam int CMD_W = 16;
    localparam int OUT_W = 16;
    localparam int LIM_W = 15;
    localparam int ACT_W = 3;

    // Internal widths that follow from the fraction width
    localparam int HOLD_W = FRAC_BITS + 2;   // signed, holds -ONE..+ONE
    localparam int MAG_W  = FRAC_BITS + 1;   // unsigned magnitude up to ONE
    localparam int SUM_W  = FRAC_BITS + 3;   // sum of three magnitudes
    localparam int REM_W  = SUM_W + 1;       // divider partial remainder
    localparam int CMP_W  = CMD_W + HOLD_W;  // width for mixed signed compares
    localparam int CNT_W  = $clog2(FRAC_BITS + 1);

    localparam logic [SUM_W-1:0] ONE_SUM = SUM_W'(1) << FRAC_BITS;
    localparam logic signed [CMP_W-1:0] ONE_CMP = CMP_W'(1) << FRAC_BITS;
    localparam logic [LIM_W-1:0] LIM_RESET = LIM_W'(6554);

endpackage

@@ sv/stm_divider.sv @@
// Restoring divider: quotient = (dividend << FRAC_BITS) / divisor, one bit per cycle.
`timescale 1ns / 1ps

module stm_divider
    import stm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [MAG_W-1:0]   dividend,   // must be below divisor
    input  logic [SUM_W-1:0]   divisor,    // held stable while busy
    output logic               done,
    output logic [FRAC_BITS-1:0] quotient
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [REM_W-1:0]     rem_reg, rem_next;
    logic [FRAC_BITS-1:0] q_reg, q_next;
    logic [REM_W:0]       shifted;
    logic [REM_W:0]       diff;

    // Trial subtract of the divisor from the doubled remainder
    assign shifted = {rem_reg, 1'b0};
    assign diff    = shifted - (REM_W + 1)'(divisor);

    // Step sequencing
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(FRAC_BITS);
            rem_next  = REM_W'(dividend);
            q_next    = '0;
        end
        else if (busy_reg)
        begin
            if (!diff[REM_W])
            begin
                rem_next = diff[REM_W-1:0];
                q_next   = {q_reg[FRAC_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[REM_W-1:0];
                q_next   = {q_reg[FRAC_BITS-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            rem_reg  <= '0;
            q_reg    <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
            rem_reg  <= rem_next;
            q_reg    <= q_next;
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

@@ sv/six_thruster_mixer_unit.sv @@
// Top level of the six thruster mixer: held axis commands, sequencer and output register.
`timescale 1ns / 1ps
//
// Usage:
//   Slave stream (s_*): one word per command. s_tuser carries the action
//   (0 throttle, 1 yaw, 2 pitch, 3 roll, 4 disarm), s_tdata the Q2.14 value.
//   Master stream (m_*): one word per command with six thruster values and
//   the disarmed flag.
//   Config channel (cfg_*): writes the yaw limit; always ready. Write it only
//   while the block is idle.
//   A command passes through clamp, sum and mix; when the sum of the three
//   Q2.14 axis magnitudes exceeds one, each axis is first normalized by the
//   one shared restoring divider, which scales pitch, roll and yaw in turn,
//   one quotient bit per cycle. One command is in work at a time; s_tready
//   is high only while the sequencer is idle, so the next command is accepted
//   only once the word of the current one is in the output register.
//   A finished word waits in the output register while the receiver stalls;
//   the next command is accepted meanwhile and its result waits until the
//   register frees.
//   Reset clears all held commands, sets the yaw limit to 0.4 and empties
//   the output register.
//

module six_thruster_mixer_unit
    import stm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [15:0]          s_tdata,   // [15:0] command_value
    input  logic [2:0]           s_tuser,   // [2:0] action
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [95:0]          m_tdata,   // a, b, c, d, e, f, 16 bits each from bit 0
    output logic [0:0]           m_tuser,   // [0] disarmed
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [14:0]          cfg_data   // [14:0] yaw_limit
);

    typedef enum logic [2:0] {
        ACT_THROTTLE = 3'd0,
        ACT_YAW      = 3'd1,
        ACT_PITCH    = 3'd2,
        ACT_ROLL     = 3'd3,
        ACT_DISARM   = 3'd4
    } action_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLAMP,
        ST_SUM,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_MIX
    } state_t;

    localparam logic [1:0] AXIS_PITCH = 2'd0;
    localparam logic [1:0] AXIS_ROLL  = 2'd1;
    localparam logic [1:0] AXIS_YAW   = 2'd2;
    localparam int MIX_W = HOLD_W + 2;

    state_t                    state_reg, state_next;
    logic signed [HOLD_W-1:0]  thr_reg, thr_next;
    logic signed [HOLD_W-1:0]  yaw_reg, yaw_next;
    logic signed [HOLD_W-1:0]  pitch_reg, pitch_next;
    logic signed [HOLD_W-1:0]  roll_reg, roll_next;
    logic signed [HOLD_W-1:0]  work_reg [3];
    logic signed [HOLD_W-1:0]  work_next [3];
    logic [SUM_W-1:0]          sum_reg, sum_next;
    logic [1:0]                axis_reg, axis_next;
    logic                      dis_reg, dis_next;
    logic [LIM_W-1:0]          lim_reg;
    logic                      m_valid_reg, m_valid_next;
    logic [95:0]               m_data_reg, m_data_next;
    logic                      m_dis_reg, m_dis_next;

    logic signed [CMP_W-1:0]   cmd_ext;
    logic signed [CMP_W-1:0]   cmd_sat;
    logic signed [HOLD_W-1:0]  cmd_hold;
    logic signed [CMP_W-1:0]   yaw_ext;
    logic signed [CMP_W-1:0]   lim_ext;
    logic signed [CMP_W-1:0]   yaw_clamped;
    logic [SUM_W-1:0]          sum_calc;
    logic signed [HOLD_W-1:0]  axis_val;
    logic [MAG_W-1:0]          axis_mag;
    logic                      div_start;
    logic                      div_done;
    logic [FRAC_BITS-1:0]      div_q;
    logic signed [HOLD_W-1:0]  scaled;
    logic signed [MIX_W-1:0]   p_m, r_m, y_m;
    logic signed [MIX_W-1:0]   mix_a, mix_b, mix_c, mix_d;

    function automatic logic [MAG_W-1:0] mag(input logic signed [HOLD_W-1:0] v);
        logic signed [HOLD_W-1:0] a;
        a = v[HOLD_W-1] ? -v : v;
        return a[MAG_W-1:0];
    endfunction

    // Saturate the incoming command to -ONE..+ONE
    assign cmd_ext  = CMP_W'($signed(s_tdata));
    assign cmd_sat  = (cmd_ext > ONE_CMP) ? ONE_CMP :
                      (cmd_ext < -ONE_CMP) ? -ONE_CMP : cmd_ext;
    assign cmd_hold = cmd_sat[HOLD_W-1:0];

    // Limit the working yaw to the configured magnitude
    assign yaw_ext     = CMP_W'(yaw_reg);
    assign lim_ext     = $signed(CMP_W'(lim_reg));
    assign yaw_clamped = (yaw_ext > lim_ext) ? lim_ext :
                         (yaw_ext < -lim_ext) ? -lim_ext : yaw_ext;

    // Sum of the three working magnitudes
    assign sum_calc = SUM_W'(mag(work_reg[0])) + SUM_W'(mag(work_reg[1]))
                    + SUM_W'(mag(work_reg[2]));

    // Selected axis for the shared divider
    assign axis_val = work_reg[axis_reg];
    assign axis_mag = mag(axis_val);
    assign scaled   = axis_val[HOLD_W-1] ? -$signed(HOLD_W'(div_q))
                                         : $signed(HOLD_W'(div_q));

    stm_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (axis_mag),
        .divisor  (sum_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    // Mix pitch, roll and yaw into the vectored thrusters
    assign p_m   = MIX_W'(work_reg[AXIS_PITCH]);
    assign r_m   = MIX_W'(work_reg[AXIS_ROLL]);
    assign y_m   = MIX_W'(work_reg[AXIS_YAW]);
    assign mix_a = p_m + r_m + y_m;
    assign mix_b = p_m - r_m - y_m;
    assign mix_c = -p_m + r_m - y_m;
    assign mix_d = -p_m - r_m + y_m;

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;

    // Sequencer next state
    always_comb
    begin
        state_next   = state_reg;
        thr_next     = thr_reg;
        yaw_next     = yaw_reg;
        pitch_next   = pitch_reg;
        roll_next    = roll_reg;
        work_next    = work_reg;
        sum_next     = sum_reg;
        axis_next    = axis_reg;
        dis_next     = dis_reg;
        m_data_next  = m_data_reg;
        m_dis_next   = m_dis_reg;
        m_valid_next = m_valid_reg;
        div_start    = 1'b0;

        // Drop the output word once taken
        if (m_valid_reg && m_tready)
        begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    dis_next = 1'b0;
                    unique case (s_tuser)
                        ACT_THROTTLE: thr_next   = cmd_hold;
                        ACT_YAW:      yaw_next   = cmd_hold;
                        ACT_PITCH:    pitch_next = cmd_hold;
                        ACT_ROLL:     roll_next  = cmd_hold;
                        ACT_DISARM:
                        begin
                            thr_next   = '0;
                            yaw_next   = '0;
                            pitch_next = '0;
                            roll_next  = '0;
                            dis_next   = 1'b1;
                        end
                        default: ;
                    endcase
                    state_next = ST_CLAMP;
                end
            end
            ST_CLAMP:
            begin
                work_next[AXIS_PITCH] = pitch_reg;
                work_next[AXIS_ROLL]  = roll_reg;
                work_next[AXIS_YAW]   = yaw_clamped[HOLD_W-1:0];
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                sum_next  = sum_calc;
                axis_next = AXIS_PITCH;
                state_next = (sum_calc > ONE_SUM) ? ST_DIV_GO : ST_MIX;
            end
            ST_DIV_GO:
            begin
                div_start  = 1'b1;
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT:
            begin
                if (div_done)
                begin
                    work_next[axis_reg] = scaled;
                    if (axis_reg == AXIS_YAW)
                    begin
                        state_next = ST_MIX;
                    end
                    else
                    begin
                        axis_next  = axis_reg + 2'd1;
                        state_next = ST_DIV_GO;
                    end
                end
            end
            ST_MIX:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    m_data_next  = {OUT_W'(thr_reg), OUT_W'(thr_reg),
                                    OUT_W'(mix_d), OUT_W'(mix_c),
                                    OUT_W'(mix_b), OUT_W'(mix_a)};
                    m_dis_next   = dis_reg;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Hold state, held commands and the output word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            thr_reg     <= '0;
            yaw_reg     <= '0;
            pitch_reg   <= '0;
            roll_reg    <= '0;
            work_reg    <= '{default: '0};
            sum_reg     <= '0;
            axis_reg    <= AXIS_PITCH;
            dis_reg     <= 1'b0;
            lim_reg     <= LIM_RESET;
            m_valid_reg <= 1'b0;
            m_data_reg  <= '0;
            m_dis_reg   <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            thr_reg     <= thr_next;
            yaw_reg     <= yaw_next;
            pitch_reg   <= pitch_next;
            roll_reg    <= roll_next;
            work_reg    <= work_next;
            sum_reg     <= sum_next;
            axis_reg    <= axis_next;
            dis_reg     <= dis_next;
            m_valid_reg <= m_valid_next;
            m_data_reg  <= m_data_next;
            m_dis_reg   <= m_dis_next;
            if (cfg_valid)
            begin
                lim_reg <= cfg_data;
            end
        end
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = m_data_reg;
    assign m_tuser[0] = m_dis_reg;

endmodule
